// File: hw/rtl/dnp_pkg.sv
// Shared constants, types and codes of the decimal number text parser
`timescale 1ns / 1ps

package dnp_pkg;

   // field widths
   localparam int CHAR_W     = 8;
   localparam int SIG_W      = 64;
   localparam int EXP_W      = 16;
   localparam int KEEP_W     = 5;
   localparam int MAG_W      = 14;
   localparam int MAGX_W     = 18;
   localparam int EXPF_W     = 18;
   localparam int PHASE_W    = 3;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_PAD_W  = RSP_DATA_W - (1 + SIG_W + EXP_W + 1);

   // limits
   localparam int MAX_DIGITS = 19;
   localparam int EXP_LIMIT  = 9999;
   localparam logic signed [EXP_W-1:0] SCALE_MAX = 16'sh7FFF;
   localparam logic signed [EXP_W-1:0] SCALE_MIN = -16'sh7FFF;
   localparam logic signed [EXPF_W-1:0] EXP_OUT_MAX = 18'sh07FFF;
   localparam logic signed [EXPF_W-1:0] EXP_OUT_MIN = -18'sh08000;

   // parse phases
   localparam logic [PHASE_W-1:0] PH_SPACE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_INT     = 3'd1;
   localparam logic [PHASE_W-1:0] PH_FRAC    = 3'd2;
   localparam logic [PHASE_W-1:0] PH_EXPSIGN = 3'd3;
   localparam logic [PHASE_W-1:0] PH_EXPDIG  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;

   // character codes
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_LOW_E = 8'h65;
   localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;

   // decoded character
   typedef struct packed {
      logic       blank;
      logic       digit;
      logic       sign;
      logic       minus;
      logic       letter;
      logic       dot;
      logic [3:0] value;
   } char_class_type;

   // one parse result
   typedef struct packed {
      logic                    inexact;
      logic signed [EXP_W-1:0] decimal_exponent;
      logic [SIG_W-1:0]        significand;
      logic                    negative;
   } result_type;

endpackage

// File: hw/rtl/dnp_classify.sv
// Character decoder: white space, digits, signs, exponent letter and point
`timescale 1ns / 1ps

module dnp_classify
   import dnp_pkg::*;
(
   input  logic [CHAR_W-1:0] character,
   output char_class_type    char_class
);

   logic [CHAR_W-1:0] digit_offset;

   // offset from '0' gives the digit value
   assign digit_offset = character - CH_ZERO;

   // decode
   always_comb begin
      char_class.blank  = (character == CH_SPACE) ||
                          (character >= CH_TAB && character <= CH_CR);
      char_class.digit  = (character >= CH_ZERO) && (character <= CH_NINE);
      char_class.sign   = (character == CH_PLUS) || (character == CH_MINUS);
      char_class.minus  = (character == CH_MINUS);
      char_class.letter = (character == CH_LOW_E) || (character == CH_UP_E);
      char_class.dot    = (character == CH_DOT);
      char_class.value  = digit_offset[3:0];
   end

endmodule

// File: hw/rtl/dnp_parse.sv
// Parse state registers and the per-character step logic
`timescale 1ns / 1ps

module dnp_parse
   import dnp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic           first,
   input  char_class_type char_class,
   output logic           result_valid,
   output result_type     result
);

   logic [PHASE_W-1:0]      phase_ff, phase_eff, phase_in;
   logic [SIG_W-1:0]        acc_ff, acc_eff, acc_in;
   logic [KEEP_W-1:0]       kept_ff, kept_eff, kept_in;
   logic                    sig_neg_ff, sig_neg_eff, sig_neg_in;
   logic [MAG_W-1:0]        mag_ff, mag_eff, mag_in;
   logic                    exp_neg_ff, exp_neg_eff, exp_neg_in;
   logic signed [EXP_W-1:0] scale_ff, scale_eff, scale_in;
   logic                    lost_ff, lost_eff, lost_in;

   logic                     int_step;
   logic                     dig_step;
   logic                     dig_frac;
   logic                     exp_step;
   logic                     fin;
   logic                     zero_lead;
   logic                     room;
   logic [SIG_W-1:0]         acc_times_ten;
   logic [MAGX_W-1:0]        mag_wide;
   logic signed [EXPF_W-1:0] mag_signed;
   logic signed [EXPF_W-1:0] exp_full;
   logic signed [EXP_W-1:0]  exp_sat;
   logic                     exp_clip;

   // a first character starts from the reset state
   always_comb begin
      if (first) begin
         phase_eff   = PH_SPACE;
         acc_eff     = '0;
         kept_eff    = '0;
         sig_neg_eff = 1'b0;
         mag_eff     = '0;
         exp_neg_eff = 1'b0;
         scale_eff   = '0;
         lost_eff    = 1'b0;
      end else begin
         phase_eff   = phase_ff;
         acc_eff     = acc_ff;
         kept_eff    = kept_ff;
         sig_neg_eff = sig_neg_ff;
         mag_eff     = mag_ff;
         exp_neg_eff = exp_neg_ff;
         scale_eff   = scale_ff;
         lost_eff    = lost_ff;
      end
   end

   // significand and exponent arithmetic
   assign zero_lead     = (acc_eff == '0) && (char_class.value == 4'd0);
   assign room          = (kept_eff < KEEP_W'(MAX_DIGITS));
   assign acc_times_ten = {acc_eff[SIG_W-4:0], 3'b000} + {acc_eff[SIG_W-2:0], 1'b0} +
                          SIG_W'(char_class.value);
   assign mag_wide      = (MAGX_W'(mag_eff) << 3) + (MAGX_W'(mag_eff) << 1) +
                          MAGX_W'(char_class.value);

   // phase decode
   always_comb begin
      phase_in   = phase_eff;
      sig_neg_in = sig_neg_eff;
      exp_neg_in = exp_neg_eff;
      int_step   = 1'b0;
      dig_step   = 1'b0;
      dig_frac   = 1'b0;
      exp_step   = 1'b0;
      fin        = 1'b0;
      unique case (phase_eff)
         PH_SPACE: begin
            if (!char_class.blank) begin
               phase_in = PH_INT;
               if (char_class.sign) begin
                  sig_neg_in = char_class.minus;
               end else begin
                  int_step = 1'b1;
               end
            end
         end
         PH_INT: begin
            int_step = 1'b1;
         end
         PH_FRAC: begin
            if (char_class.digit) begin
               dig_step = 1'b1;
               dig_frac = 1'b1;
            end else if (char_class.letter) begin
               phase_in = PH_EXPSIGN;
            end else begin
               fin = 1'b1;
            end
         end
         PH_EXPSIGN: begin
            if (char_class.sign) begin
               exp_neg_in = char_class.minus;
               phase_in   = PH_EXPDIG;
            end else if (char_class.digit) begin
               phase_in = PH_EXPDIG;
               exp_step = 1'b1;
            end else begin
               fin = 1'b1;
            end
         end
         PH_EXPDIG: begin
            if (char_class.digit) begin
               exp_step = 1'b1;
            end else begin
               fin = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // integer part, also reached straight from white space
      if (int_step) begin
         if (char_class.digit) begin
            dig_step = 1'b1;
         end else if (char_class.dot) begin
            phase_in = PH_FRAC;
         end else if (char_class.letter) begin
            phase_in = PH_EXPSIGN;
         end else begin
            fin = 1'b1;
         end
      end
      if (fin) begin
         phase_in = PH_DONE;
      end
   end

   // digit and exponent updates
   always_comb begin
      acc_in   = acc_eff;
      kept_in  = kept_eff;
      mag_in   = mag_eff;
      scale_in = scale_eff;
      lost_in  = lost_eff;
      if (dig_step) begin
         if (!zero_lead && room) begin
            acc_in  = acc_times_ten;
            kept_in = kept_eff + KEEP_W'(1);
         end
         if (!zero_lead && !room && char_class.value != 4'd0) begin
            lost_in = 1'b1;
         end
         if (dig_frac && (zero_lead || room)) begin
            if (scale_eff < SCALE_MAX) begin
               scale_in = scale_eff + 16'sd1;
            end else begin
               lost_in = 1'b1;
            end
         end
         if (!dig_frac && !zero_lead && !room) begin
            if (scale_eff > SCALE_MIN) begin
               scale_in = scale_eff - 16'sd1;
            end else begin
               lost_in = 1'b1;
            end
         end
      end
      if (exp_step) begin
         if (mag_wide > MAGX_W'(EXP_LIMIT)) begin
            mag_in  = MAG_W'(EXP_LIMIT);
            lost_in = 1'b1;
         end else begin
            mag_in = mag_wide[MAG_W-1:0];
         end
      end
   end

   // final exponent with saturation
   always_comb begin
      mag_signed = $signed({{(EXPF_W-MAG_W){1'b0}}, mag_eff});
      exp_full   = (exp_neg_eff ? -mag_signed : mag_signed) -
                   $signed({{(EXPF_W-EXP_W){scale_eff[EXP_W-1]}}, scale_eff});
      exp_clip   = 1'b0;
      if (exp_full > EXP_OUT_MAX) begin
         exp_sat  = EXP_OUT_MAX[EXP_W-1:0];
         exp_clip = 1'b1;
      end else if (exp_full < EXP_OUT_MIN) begin
         exp_sat  = EXP_OUT_MIN[EXP_W-1:0];
         exp_clip = 1'b1;
      end else begin
         exp_sat = exp_full[EXP_W-1:0];
      end
   end

   // result of the ending character
   assign result_valid            = step & fin;
   assign result.negative         = sig_neg_eff;
   assign result.significand      = acc_eff;
   assign result.decimal_exponent = exp_sat;
   assign result.inexact          = lost_eff | exp_clip;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SPACE;
         acc_ff     <= '0;
         kept_ff    <= '0;
         sig_neg_ff <= 1'b0;
         mag_ff     <= '0;
         exp_neg_ff <= 1'b0;
         scale_ff   <= '0;
         lost_ff    <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         kept_ff    <= kept_in;
         sig_neg_ff <= sig_neg_in;
         mag_ff     <= mag_in;
         exp_neg_ff <= exp_neg_in;
         scale_ff   <= scale_in;
         lost_ff    <= lost_in;
      end
   end

endmodule

// File: hw/rtl/decimal_number_text_parser_core.sv
// Top level of the decimal number text parser: input register, parser, result register
`timescale 1ns / 1ps

// Parses a decimal number one character per item and gives one result item when the
// first character that does not continue the number arrives (NUL included). Set
// req_tuser to start a new string. One item can be taken every clock cycle while no
// waiting result holds the input register. The ending character is held in the input
// register until the result register can advance; its result item is registered there
// and offered from it. The per-cycle work is a character decode and one
// multiply-by-ten-and-add each of the significand and the exponent. A waiting result
// does not stop the input register from taking one more item.
module decimal_number_text_parser_core
   import dnp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // character[7:0]
   input  logic                  req_tuser,  // first
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // negative[0], significand[64:1], decimal_exponent[80:65], inexact[81], zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_first_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;

   logic           advance;
   logic           process;
   logic           req_take;
   char_class_type char_class;
   logic           res_valid;
   result_type     res;

   // handshake control
   assign advance     = !rsp_valid_ff || rsp_tready;
   assign process     = in_valid_ff && advance;
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !process);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff  <= req_tdata[CHAR_W-1:0];
         in_first_ff <= req_tuser;
      end
   end

   // character decode
   dnp_classify u_classify (
      .character  (in_char_ff),
      .char_class (char_class)
   );

   // parse state and step
   dnp_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (process),
      .first        (in_first_ff),
      .char_class   (char_class),
      .result_valid (res_valid),
      .result       (res)
   );

   // result register
   assign rsp_valid_in = advance ? res_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_data_ff};

endmodule

// File: hw/rtl/dnp_checker.sv
// Port checks of the decimal number text parser and their binding
`timescale 1ns / 1ps

module dnp_checker
   import dnp_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // a stalled result keeps its value
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing offered right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // a fresh result follows an item taken before it
   a_rsp_cause : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without an ending item");

endmodule

bind decimal_number_text_parser_core dnp_checker u_dnp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/decimal_number_text_parser_checker.sv
// Checker of the decimal number text parser: predicts results from accepted items and compares
`timescale 1ns / 1ps

module decimal_number_text_parser_checker
   import dnp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // character[7:0]
   input  logic                  req_tuser,  // first
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // negative[0], significand[64:1], decimal_exponent[80:65], inexact[81], zero pad
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatch_count,
   output int                    results_pending
);

   // predicted parser state
   logic [PHASE_W-1:0] parse_phase;
   logic [SIG_W-1:0]   digits_value;
   int                 digits_kept;
   logic               mantissa_minus;
   int                 exp_value;
   logic               exp_minus;
   int                 frac_scale;
   logic               precision_lost;

   result_type         expected_results[$];
   result_type         got_result;
   result_type         want_result;
   int                 mismatches;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
   endtask

   function automatic void clear_parse();
      parse_phase    = PH_SPACE;
      digits_value   = '0;
      digits_kept    = 0;
      mantissa_minus = 1'b0;
      exp_value      = 0;
      exp_minus      = 1'b0;
      frac_scale     = 0;
      precision_lost = 1'b0;
   endfunction

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   // fraction digits count up, dropped integer digits count down, both saturating
   function automatic void step_scale(input logic up);
      if (up) begin
         if (frac_scale < 32767) frac_scale++;
         else precision_lost = 1'b1;
      end else begin
         if (frac_scale > -32767) frac_scale--;
         else precision_lost = 1'b1;
      end
   endfunction

   function automatic void take_sig_digit(input int d, input logic in_frac);
      // leading zeros take no digit place
      if (digits_value == '0 && d == 0) begin
         if (in_frac) step_scale(1'b1);
         return;
      end
      if (digits_kept < MAX_DIGITS) begin
         digits_value = digits_value * 64'd10 + SIG_W'(d);
         digits_kept++;
         if (in_frac) step_scale(1'b1);
      end else begin
         if (d != 0) precision_lost = 1'b1;
         if (!in_frac) step_scale(1'b0);
      end
   endfunction

   function automatic void take_exp_digit(input int d);
      exp_value = exp_value * 10 + d;
      if (exp_value > EXP_LIMIT) begin
         exp_value      = EXP_LIMIT;
         precision_lost = 1'b1;
      end
   endfunction

   function automatic void close_parse();
      int         e;
      result_type r;
      e = exp_minus ? -exp_value : exp_value;
      e -= frac_scale;
      r.inexact = precision_lost;
      if (e > 32767) begin
         e         = 32767;
         r.inexact = 1'b1;
      end
      if (e < -32768) begin
         e         = -32768;
         r.inexact = 1'b1;
      end
      r.negative         = mantissa_minus;
      r.significand      = digits_value;
      r.decimal_exponent = EXP_W'(e);
      parse_phase = PH_DONE;
      expected_results.push_back(r);
   endfunction

   // one character through the parse phases
   function automatic void parse_char(input logic [CHAR_W-1:0] c, input logic restart);
      logic is_sign;
      logic is_letter;
      is_sign   = (c == CH_PLUS || c == CH_MINUS);
      is_letter = (c == CH_LOW_E || c == CH_UP_E);
      if (restart) clear_parse();
      if (parse_phase == PH_SPACE) begin
         if (is_blank(c)) return;
         parse_phase = PH_INT;
         if (is_sign) begin
            mantissa_minus = (c == CH_MINUS);
            return;
         end
      end
      if (parse_phase == PH_INT) begin
         if (is_digit(c)) take_sig_digit(int'(c - CH_ZERO), 1'b0);
         else if (c == CH_DOT) parse_phase = PH_FRAC;
         else if (is_letter) parse_phase = PH_EXPSIGN;
         else close_parse();
         return;
      end
      if (parse_phase == PH_FRAC) begin
         if (is_digit(c)) take_sig_digit(int'(c - CH_ZERO), 1'b1);
         else if (is_letter) parse_phase = PH_EXPSIGN;
         else close_parse();
         return;
      end
      if (parse_phase == PH_EXPSIGN) begin
         if (is_sign) begin
            exp_minus   = (c == CH_MINUS);
            parse_phase = PH_EXPDIG;
            return;
         end
         if (!is_digit(c)) begin
            close_parse();
            return;
         end
         parse_phase = PH_EXPDIG;
      end
      if (parse_phase == PH_EXPDIG) begin
         if (is_digit(c)) take_exp_digit(int'(c - CH_ZERO));
         else close_parse();
      end
   endfunction

   // compare results, then predict from the accepted item
   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_result = rsp_tdata[$bits(result_type)-1:0];
            if (expected_results.size() == 0) begin
               report_mismatch("result item with none expected");
            end else begin
               want_result = expected_results.pop_front();
               if (got_result.negative !== want_result.negative)
                  report_mismatch($sformatf("negative %0b, expected %0b",
                     got_result.negative, want_result.negative));
               if (got_result.significand !== want_result.significand)
                  report_mismatch($sformatf("significand %0d, expected %0d",
                     got_result.significand, want_result.significand));
               if (got_result.decimal_exponent !== want_result.decimal_exponent)
                  report_mismatch($sformatf("decimal_exponent %0d, expected %0d",
                     got_result.decimal_exponent, want_result.decimal_exponent));
               if (got_result.inexact !== want_result.inexact)
                  report_mismatch($sformatf("inexact %0b, expected %0b",
                     got_result.inexact, want_result.inexact));
            end
         end
         if (req_tvalid && req_tready) parse_char(req_tdata[CHAR_W-1:0], req_tuser);
      end
      mismatch_count  <= mismatches;
      results_pending <= expected_results.size();
   end

endmodule

// File: sim/decimal_number_text_parser_core_test.sv
// Testbench top of the decimal number text parser: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module decimal_number_text_parser_core_test;
   import dnp_pkg::*;

   localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // character[7:0]
   logic                  req_tuser  = 1'b0;  // first
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // negative[0], significand[64:1], decimal_exponent[80:65], inexact[81], zero pad
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int mismatch_count;
   int results_pending;
   int req_idle_pct = 35;
   int rsp_idle_pct = 64;
   int items_sent   = 0;

   // string waiting to go out, each entry {first, character}
   logic [CHAR_W:0] string_items[$];

   decimal_number_text_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   decimal_number_text_parser_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always #5 clock = ~clock;

   // result side back-pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // run guard
   initial begin
      #500_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_char(input logic [CHAR_W-1:0] c, input logic restart);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_queued();
      logic [CHAR_W:0] entry;
      while (string_items.size() != 0) begin
         entry = string_items.pop_front();
         send_char(entry[CHAR_W-1:0], entry[CHAR_W]);
      end
   endtask

   // the first character of a string carries the restart flag
   task automatic queue_char(input logic [CHAR_W-1:0] c);
      string_items.push_back({string_items.size() == 0, c});
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_char(s[i]);
   endtask

   task automatic queue_zeros(input int n);
      repeat (n) queue_char(CH_ZERO);
   endtask

   task automatic queue_digits(input int n);
      repeat (n) queue_char(CHAR_W'(CH_ZERO + $urandom_range(9)));
   endtask

   task automatic queue_sign();
      case ($urandom_range(2))
         0: queue_char(CH_PLUS);
         1: queue_char(CH_MINUS);
         default: ;
      endcase
   endtask

   // well-formed number with random content, sometimes too long or unterminated
   task automatic build_number();
      case ($urandom_range(3))
         0: queue_char(CH_SPACE);
         1: queue_char(CHAR_W'(CH_TAB + $urandom_range(4)));
         default: ;
      endcase
      queue_sign();
      if ($urandom_range(3) == 0) queue_zeros($urandom_range(1, 3));
      queue_digits(($urandom_range(7) == 0) ? $urandom_range(17, 24) : $urandom_range(6));
      if ($urandom_range(1)) begin
         queue_char(CH_DOT);
         if ($urandom_range(3) == 0) queue_zeros($urandom_range(1, 3));
         queue_digits(($urandom_range(7) == 0) ? $urandom_range(17, 24) : $urandom_range(6));
      end
      if ($urandom_range(1)) begin
         queue_char($urandom_range(1) ? CH_LOW_E : CH_UP_E);
         queue_sign();
         queue_digits($urandom_range(5));
      end
      // ending character
      case ($urandom_range(7))
         0, 1, 2: queue_char(CH_NUL);
         3, 4, 5, 6: queue_char(CHAR_W'($urandom_range(255)));
         default: ;
      endcase
      if ($urandom_range(3) == 0) begin
         repeat ($urandom_range(1, 3)) queue_char(CHAR_W'($urandom_range(255)));
      end
   endtask

   // random bytes, with restarts scattered inside
   task automatic build_noise();
      int n;
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++)
         string_items.push_back({(i == 0) || ($urandom_range(3) == 0),
                                 CHAR_W'($urandom_range(255))});
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   task automatic run_random(input int req_pct, input int rsp_pct, input int item_goal);
      int start_count;
      req_idle_pct = req_pct;
      rsp_idle_pct <= rsp_pct;
      start_count = items_sent;
      while (items_sent - start_count < item_goal) begin
         if ($urandom_range(6) == 0) build_noise();
         else build_number();
         send_queued();
      end
      hold_until_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // blank, plus sign, leading zero, fraction, upper-case letter, negative exponent
      queue_text("\t+012.50E-3;");
      send_queued();
      // no digits, letter without exponent digits, ends on nul
      queue_text("-.e");
      queue_char(CH_NUL);
      send_queued();
      // top byte ends the parse at once
      queue_char(8'hFF);
      send_queued();
      // unterminated string cut by a restart, then a saturating exponent
      queue_char(CH_NINE);
      send_queued();
      queue_text("9e99999 ?");
      send_queued();
      hold_until_drained();

      run_random(35, 64, 440);
      run_random(64, 35, 450);
      run_random(0, 0, 450);

      hold_until_drained();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: decimal_number_text_parser_core.f
hw/rtl/dnp_pkg.sv
hw/rtl/dnp_classify.sv
hw/rtl/dnp_parse.sv
hw/rtl/decimal_number_text_parser_core.sv
hw/rtl/dnp_checker.sv
sim/decimal_number_text_parser_checker.sv
sim/decimal_number_text_parser_core_test.sv
